FILE: hw/rtl/seconds_to_date_time_digits_assert.svh
// Assertion macros used by the seconds-to-date/time top level.
`ifndef SECONDS_TO_DATE_TIME_DIGITS_ASSERT_SVH
`define SECONDS_TO_DATE_TIME_DIGITS_ASSERT_SVH

// Clocked check, disabled while rst_n is low; clk and rst_n must be in scope.
`define STDT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that must hold whenever a result word is presented on out_valid.
`define STDT_ASSERT_OUT(label, cond, msg) \
  `STDT_ASSERT(label, out_valid |-> (cond), msg)

`endif

FILE: hw/rtl/stdt_pkg.sv
// Shared types, constants and helper functions for the seconds-to-date/time pipeline.
`default_nettype none

package stdt_pkg;

  localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
  localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
  localparam logic [5:0]  SECS_PER_MIN  = 6'd60;
  localparam logic [8:0]  DAYS_IN_YEAR  = 9'd365;
  localparam int unsigned MONTHS        = 12;
  localparam logic [3:0]  MONTH_OOR     = 4'd12;

  // Exact reciprocals: day = (count>>7)/675, hour = (tod>>4)/225, minute = (rem>>2)/15
  localparam logic [18:0] DAY_RECIP  = 19'd397683;
  localparam logic [13:0] HOUR_RECIP = 14'd9321;
  localparam logic [10:0] MIN_RECIP  = 11'd1093;
  localparam logic [7:0]  TEN_RECIP  = 8'd205;

  // zero-based day of year on which each month starts
  localparam logic [8:0] MONTH_START [MONTHS] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  typedef struct packed {
    logic [2:0] tens;
    logic [3:0] ones;
  } digits_t;

  // after the day split
  typedef struct packed {
    logic [16:0] tod;
    logic [8:0]  doy;
    logic [3:0]  month;
    logic        oor;
  } day_word_t;

  // after date digits and hour split
  typedef struct packed {
    logic [3:0]  month;
    logic        oor;
    logic [1:0]  day_tens;
    logic [3:0]  day_ones;
    logic [1:0]  hour_tens;
    logic [3:0]  hour_ones;
    logic [11:0] rem;
  } date_word_t;

  typedef struct packed {
    logic [3:0] month;
    logic [1:0] day_tens;
    logic [3:0] day_ones;
    logic [1:0] hour_tens;
    logic [3:0] hour_ones;
    logic [2:0] minute_tens;
    logic [3:0] minute_ones;
    logic [2:0] second_tens;
    logic [3:0] second_ones;
    logic       oor;
  } result_t;

  // month index for a day of year below 365
  function automatic logic [3:0] month_of(input logic [8:0] doy);
    logic [3:0] m;
    m = '0;
    for (int i = 1; i < MONTHS; i++) begin
      if (doy >= MONTH_START[i]) m = 4'(i);
    end
    return m;
  endfunction

  // one-based day of month, zero when the month code is out of range
  function automatic logic [4:0] day_of_month(input logic [8:0] doy, input logic [3:0] month);
    logic [8:0] d;
    d = '0;
    if (month < 4'(MONTHS)) d = doy - MONTH_START[month] + 9'd1;
    return d[4:0];
  endfunction

  // decimal split of a value below 64: tens = (y*205)>>11
  function automatic digits_t split10(input logic [5:0] y);
    logic [13:0] prod;
    logic [5:0]  ones;
    digits_t     r;
    prod   = 14'(y) * 14'(TEN_RECIP);
    r.tens = prod[13:11];
    ones   = y - 6'(r.tens) * 6'd10;
    r.ones = ones[3:0];
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/stdt_day_split.sv
// Stages 1-2: day of year and time of day from the seconds count, month lookup.
`default_nettype none

module stdt_day_split (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [24:0]       in_seconds_count,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output stdt_pkg::day_word_t    out_word
);
  import stdt_pkg::*;

  logic        s1_valid_r;
  logic [24:0] s1_count_r;
  logic [8:0]  s1_doy_r;
  logic        s2_valid_r;
  day_word_t   s2_word_r;

  logic        s1_en;
  logic        s2_en;
  logic [36:0] s1_prod;
  logic [8:0]  s1_doy_nxt;
  logic [24:0] s2_tod_full;
  day_word_t   s2_word_nxt;

  assign s2_en    = !s2_valid_r || out_ready;
  assign s1_en    = !s1_valid_r || s2_en;
  assign in_ready = s1_en;

  // count/86400 = (count>>7)/675, exact over the full 25-bit range
  assign s1_prod    = 37'(in_seconds_count[24:7]) * 37'(DAY_RECIP);
  assign s1_doy_nxt = s1_prod[36:28];

  always_comb begin
    s2_tod_full       = s1_count_r - 25'(s1_doy_r) * 25'(SECS_PER_DAY);
    s2_word_nxt.tod   = s2_tod_full[16:0];
    s2_word_nxt.doy   = s1_doy_r;
    s2_word_nxt.oor   = (s1_doy_r >= DAYS_IN_YEAR);
    s2_word_nxt.month = s2_word_nxt.oor ? MONTH_OOR : month_of(s1_doy_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (s1_en) s1_valid_r <= in_valid;
      if (s2_en) s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_count_r <= in_seconds_count;
      s1_doy_r   <= s1_doy_nxt;
    end
    if (s2_en) s2_word_r <= s2_word_nxt;
  end

  assign out_valid = s2_valid_r;
  assign out_word  = s2_word_r;

endmodule

`default_nettype wire

FILE: hw/rtl/stdt_date_time.sv
// Stages 3-4: hour split, day of month, date and hour digits.
`default_nettype none

module stdt_date_time (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire stdt_pkg::day_word_t in_word,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output stdt_pkg::date_word_t   out_word
);
  import stdt_pkg::*;

  typedef struct packed {
    logic [16:0] tod;
    logic [4:0]  hr;
    logic [4:0]  dom;
    logic [3:0]  month;
    logic        oor;
  } hour_word_t;

  logic       s3_valid_r;
  hour_word_t s3_word_r;
  logic       s4_valid_r;
  date_word_t s4_word_r;

  logic        s3_en;
  logic        s4_en;
  logic [26:0] s3_prod;
  hour_word_t  s3_word_nxt;
  logic [16:0] s4_rem_full;
  digits_t     s4_day_dig;
  digits_t     s4_hour_dig;
  date_word_t  s4_word_nxt;

  assign s4_en    = !s4_valid_r || out_ready;
  assign s3_en    = !s3_valid_r || s4_en;
  assign in_ready = s3_en;

  // tod/3600 = (tod>>4)/225, exact for tod below 86400
  always_comb begin
    s3_prod           = 27'(in_word.tod[16:4]) * 27'(HOUR_RECIP);
    s3_word_nxt.tod   = in_word.tod;
    s3_word_nxt.hr    = s3_prod[25:21];
    s3_word_nxt.dom   = day_of_month(in_word.doy, in_word.month);
    s3_word_nxt.month = in_word.month;
    s3_word_nxt.oor   = in_word.oor;
  end

  always_comb begin
    s4_rem_full           = s3_word_r.tod - 17'(s3_word_r.hr) * 17'(SECS_PER_HOUR);
    s4_day_dig            = split10(6'(s3_word_r.dom));
    s4_hour_dig           = split10(6'(s3_word_r.hr));
    s4_word_nxt.month     = s3_word_r.month;
    s4_word_nxt.oor       = s3_word_r.oor;
    s4_word_nxt.day_tens  = s4_day_dig.tens[1:0];
    s4_word_nxt.day_ones  = s4_day_dig.ones;
    s4_word_nxt.hour_tens = s4_hour_dig.tens[1:0];
    s4_word_nxt.hour_ones = s4_hour_dig.ones;
    s4_word_nxt.rem       = s4_rem_full[11:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else begin
      if (s3_en) s3_valid_r <= in_valid;
      if (s4_en) s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_en) s3_word_r <= s3_word_nxt;
    if (s4_en) s4_word_r <= s4_word_nxt;
  end

  assign out_valid = s4_valid_r;
  assign out_word  = s4_word_r;

endmodule

`default_nettype wire

FILE: hw/rtl/stdt_min_sec.sv
// Stages 5-7: minute and second split and their digits; stage 7 is the output register.
`default_nettype none

module stdt_min_sec (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire stdt_pkg::date_word_t in_word,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output stdt_pkg::result_t        out_word
);
  import stdt_pkg::*;

  typedef struct packed {
    date_word_t  date;
    logic [5:0]  mn;
  } min_word_t;

  typedef struct packed {
    result_t     res;
    logic [5:0]  sc;
  } sec_word_t;

  logic      s5_valid_r;
  min_word_t s5_word_r;
  logic      s6_valid_r;
  sec_word_t s6_word_r;
  logic      s7_valid_r;
  result_t   s7_word_r;

  logic        s5_en;
  logic        s6_en;
  logic        s7_en;
  logic [19:0] s5_prod;
  min_word_t   s5_word_nxt;
  logic [11:0] s6_sc_full;
  digits_t     s6_min_dig;
  sec_word_t   s6_word_nxt;
  digits_t     s7_sec_dig;
  result_t     s7_word_nxt;

  assign s7_en    = !s7_valid_r || out_ready;
  assign s6_en    = !s6_valid_r || s7_en;
  assign s5_en    = !s5_valid_r || s6_en;
  assign in_ready = s5_en;

  // rem/60 = (rem>>2)/15, exact for rem below 3600
  always_comb begin
    s5_prod          = 20'(in_word.rem[11:2]) * 20'(MIN_RECIP);
    s5_word_nxt.date = in_word;
    s5_word_nxt.mn   = s5_prod[19:14];
  end

  always_comb begin
    s6_sc_full                  = s5_word_r.date.rem - 12'(s5_word_r.mn) * 12'(SECS_PER_MIN);
    s6_min_dig                  = split10(s5_word_r.mn);
    s6_word_nxt.res.month       = s5_word_r.date.month;
    s6_word_nxt.res.day_tens    = s5_word_r.date.day_tens;
    s6_word_nxt.res.day_ones    = s5_word_r.date.day_ones;
    s6_word_nxt.res.hour_tens   = s5_word_r.date.hour_tens;
    s6_word_nxt.res.hour_ones   = s5_word_r.date.hour_ones;
    s6_word_nxt.res.minute_tens = s6_min_dig.tens;
    s6_word_nxt.res.minute_ones = s6_min_dig.ones;
    s6_word_nxt.res.second_tens = '0;
    s6_word_nxt.res.second_ones = '0;
    s6_word_nxt.res.oor         = s5_word_r.date.oor;
    s6_word_nxt.sc              = s6_sc_full[5:0];
  end

  always_comb begin
    s7_sec_dig              = split10(s6_word_r.sc);
    s7_word_nxt             = s6_word_r.res;
    s7_word_nxt.second_tens = s7_sec_dig.tens;
    s7_word_nxt.second_ones = s7_sec_dig.ones;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_valid_r <= 1'b0;
      s6_valid_r <= 1'b0;
      s7_valid_r <= 1'b0;
    end else begin
      if (s5_en) s5_valid_r <= in_valid;
      if (s6_en) s6_valid_r <= s5_valid_r;
      if (s7_en) s7_valid_r <= s6_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s5_en) s5_word_r <= s5_word_nxt;
    if (s6_en) s6_word_r <= s6_word_nxt;
    if (s7_en) s7_word_r <= s7_word_nxt;
  end

  assign out_valid = s7_valid_r;
  assign out_word  = s7_word_r;

endmodule

`default_nettype wire

FILE: hw/rtl/seconds_to_date_time_digits.sv
// Top level: seconds since Jan 1 00:00:00 to month, day and time digits.
//
// Input channel: in_valid/in_ready with in_seconds_count (25 bits, seconds
// since midnight of January 1 of a non-leap year). One word in, one word out.
// Output channel: out_valid/out_ready with month (0..11, 12 = past year end),
// decimal tens/ones digits of day of month, hour, minute and second, and
// out_of_range. Past day 365 the date digits read zero; time digits still valid.
//
// Seven register stages: a word accepted into stage 1 moves through stages
// 2 to 7 and is presented on out_valid from the stage 7 register. Throughput
// is one word per cycle while out_ready is high; all divides are by constants,
// done as reciprocal multiplies with at most one wide multiply per stage.
// Each stage advances when it is empty or the stage after it advances, so
// bubbles are squeezed out and in_ready stays high while any stage is empty.
// When the receiver holds out_ready low the pipe fills up to seven words,
// then in_ready drops; nothing is dropped or repeated.
// Synchronous reset (rst_n low) clears all stage valid bits; the pipe comes
// up empty and ready.
`default_nettype none

`include "seconds_to_date_time_digits_assert.svh"

module seconds_to_date_time_digits (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [24:0] in_seconds_count,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       out_month,
  output logic [1:0]       out_day_tens,
  output logic [3:0]       out_day_ones,
  output logic [1:0]       out_hour_tens,
  output logic [3:0]       out_hour_ones,
  output logic [2:0]       out_minute_tens,
  output logic [3:0]       out_minute_ones,
  output logic [2:0]       out_second_tens,
  output logic [3:0]       out_second_ones,
  output logic             out_out_of_range
);
  import stdt_pkg::*;

  // day split -> date/hour
  logic       day_valid;
  logic       day_ready;
  day_word_t  day_word;
  // date/hour -> minute/second
  logic       date_valid;
  logic       date_ready;
  date_word_t date_word;
  result_t    res_word;

  // stages 1-2: count/86400, time of day, month lookup
  stdt_day_split u_day_split (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_seconds_count (in_seconds_count),
    .out_valid        (day_valid),
    .out_ready        (day_ready),
    .out_word         (day_word)
  );

  // stages 3-4: hour, day of month, date and hour digits
  stdt_date_time u_date_time (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (day_valid),
    .in_ready  (day_ready),
    .in_word   (day_word),
    .out_valid (date_valid),
    .out_ready (date_ready),
    .out_word  (date_word)
  );

  // stages 5-7: minute, second and their digits; last stage drives the ports
  stdt_min_sec u_min_sec (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (date_valid),
    .in_ready  (date_ready),
    .in_word   (date_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (res_word)
  );

  assign out_month        = res_word.month;
  assign out_day_tens     = res_word.day_tens;
  assign out_day_ones     = res_word.day_ones;
  assign out_hour_tens    = res_word.hour_tens;
  assign out_hour_ones    = res_word.hour_ones;
  assign out_minute_tens  = res_word.minute_tens;
  assign out_minute_ones  = res_word.minute_ones;
  assign out_second_tens  = res_word.second_tens;
  assign out_second_ones  = res_word.second_ones;
  assign out_out_of_range = res_word.oor;

  // out-of-range flag and month code must agree
  `STDT_ASSERT_OUT(a_oor_month, out_out_of_range == (out_month == MONTH_OOR), "oor/month mismatch")
  // past year end the date digits are zero
  `STDT_ASSERT_OUT(a_oor_day_zero, !out_out_of_range || (out_day_tens == 2'd0 && out_day_ones == 4'd0), "date digits set past year end")
  // inside the year the day of month is at least one
  `STDT_ASSERT_OUT(a_day_nonzero, out_out_of_range || out_day_tens != 2'd0 || out_day_ones != 4'd0, "day of month zero")
  // hour stays below 24
  `STDT_ASSERT_OUT(a_hour_range, out_hour_tens != 2'd3 && !(out_hour_tens == 2'd2 && out_hour_ones > 4'd3), "hour out of range")

endmodule

`default_nettype wire
